### rtl/plar_pkg.sv
package plar_pkg;

  localparam int COORD_BITS    = 24;
  localparam int MAX_POINTS    = 64;
  localparam int SPACING_BITS  = 24;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 24'd256;

  // Magnitude of a coordinate difference, segment length and carried distance
  localparam int MAG_BITS      = COORD_BITS;
  localparam int LEN_BITS      = COORD_BITS + 1;
  localparam int DIST_BITS     = LEN_BITS;
  localparam int SQ_BITS       = 2 * MAG_BITS;
  localparam int RAD_BITS      = 2 * LEN_BITS;
  localparam int SREM_BITS     = LEN_BITS + 2;
  localparam int NUM_BITS      = MAG_BITS + LEN_BITS;
  localparam int K_BITS        = $clog2(MAX_POINTS + 1);
  localparam int SPAN_BITS     = SPACING_BITS + K_BITS;
  localparam int CNT_BITS      = $clog2(LEN_BITS + 1);

  localparam int SQRT_STEPS    = LEN_BITS;
  localparam int REM_STEPS     = LEN_BITS;
  localparam int QUO_STEPS     = MAG_BITS;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  // One classified vertex: either a stroke start or a segment from prev
  typedef struct packed {
    logic                         is_start;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         neg_x;
    logic                         neg_y;
    logic [MAG_BITS-1:0]          ax;
    logic [MAG_BITS-1:0]          ay;
  } seg_t;

endpackage

### rtl/plar_vertex_if.sv
interface plar_vertex_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   start_of_stroke;
  logic signed [plar_pkg::COORD_BITS-1:0] vertex_x;
  logic signed [plar_pkg::COORD_BITS-1:0] vertex_y;

  modport source (output valid, start_of_stroke, vertex_x, vertex_y, input ready);
  modport sink   (input valid, start_of_stroke, vertex_x, vertex_y, output ready);
endinterface

### rtl/plar_point_if.sv
interface plar_point_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [plar_pkg::COORD_BITS-1:0] point_x;
  logic signed [plar_pkg::COORD_BITS-1:0] point_y;
  logic                                   last_of_run;
  logic                                   overflow;

  modport source (output valid, point_x, point_y, last_of_run, overflow, input ready);
  modport sink   (input valid, point_x, point_y, last_of_run, overflow, output ready);
endinterface

### rtl/plar_front.sv
module plar_front (
  input  logic                clk,
  input  logic                rst,
  plar_vertex_if.sink         vertex,
  input  logic                queue_full,
  output logic                push,
  output plar_pkg::seg_t      entry
);

  logic signed [plar_pkg::COORD_BITS-1:0] prev_x;
  logic signed [plar_pkg::COORD_BITS-1:0] prev_y;
  logic                                   have_prev;
  logic [plar_pkg::LEN_BITS-1:0]          dx;
  logic [plar_pkg::LEN_BITS-1:0]          dy;
  logic [plar_pkg::LEN_BITS-1:0]          mx;
  logic [plar_pkg::LEN_BITS-1:0]          my;
  logic                                   starts;

  assign vertex.ready = !queue_full;
  assign push         = vertex.valid && !queue_full;
  assign starts       = vertex.start_of_stroke || !have_prev;

  // Difference to the previous vertex and its magnitude
  assign dx = {vertex.vertex_x[plar_pkg::COORD_BITS-1], vertex.vertex_x}
            - {prev_x[plar_pkg::COORD_BITS-1], prev_x};
  assign dy = {vertex.vertex_y[plar_pkg::COORD_BITS-1], vertex.vertex_y}
            - {prev_y[plar_pkg::COORD_BITS-1], prev_y};
  assign mx = dx[plar_pkg::LEN_BITS-1] ? -dx : dx;
  assign my = dy[plar_pkg::LEN_BITS-1] ? -dy : dy;

  // Classify the transaction
  always_comb begin
    entry.is_start = starts;
    entry.px       = starts ? vertex.vertex_x : prev_x;
    entry.py       = starts ? vertex.vertex_y : prev_y;
    entry.neg_x    = dx[plar_pkg::LEN_BITS-1];
    entry.neg_y    = dy[plar_pkg::LEN_BITS-1];
    entry.ax       = mx[plar_pkg::MAG_BITS-1:0];
    entry.ay       = my[plar_pkg::MAG_BITS-1:0];
  end

  // Track the previous vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
    end else if (push) begin
      prev_x    <= vertex.vertex_x;
      prev_y    <= vertex.vertex_y;
      have_prev <= 1'b1;
    end
  end

endmodule

### rtl/plar_queue.sv
module plar_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  plar_pkg::seg_t push_entry,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output plar_pkg::seg_t head
);

  plar_pkg::seg_t                 entries [plar_pkg::QUEUE_DEPTH];
  logic [plar_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [plar_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [plar_pkg::QCNT_BITS-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign full       = (count == plar_pkg::QCNT_BITS'(plar_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/plar_back.sv
module plar_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [plar_pkg::SPACING_BITS-1:0]   sp,
  input  logic                                head_valid,
  input  plar_pkg::seg_t                      head,
  output logic                                pop,
  plar_point_if.source                        point
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SQUARE, S_ADD, S_SQRT, S_CHECK, S_REM, S_PMUL, S_PDIV, S_EMIT
  } state_t;

  state_t                                 state;
  plar_pkg::seg_t                         seg;
  logic [plar_pkg::SQ_BITS-1:0]           sqx;
  logic [plar_pkg::SQ_BITS-1:0]           sqy;
  logic [plar_pkg::RAD_BITS-1:0]          rad;
  logic [plar_pkg::SREM_BITS-1:0]         srem;
  logic [plar_pkg::LEN_BITS-1:0]          root;
  logic [plar_pkg::LEN_BITS-1:0]          len;
  logic [plar_pkg::DIST_BITS-1:0]         carry;
  logic [plar_pkg::LEN_BITS-1:0]          rnum;
  logic [plar_pkg::LEN_BITS-1:0]          rrem;
  logic                                   ovf;
  logic [plar_pkg::LEN_BITS-1:0]          d;
  logic [plar_pkg::K_BITS-1:0]            k;
  logic [plar_pkg::LEN_BITS-1:0]          remx;
  logic [plar_pkg::LEN_BITS-1:0]          remy;
  logic [plar_pkg::MAG_BITS-1:0]          lox;
  logic [plar_pkg::MAG_BITS-1:0]          loy;
  logic [plar_pkg::MAG_BITS-1:0]          qx;
  logic [plar_pkg::MAG_BITS-1:0]          qy;
  logic [plar_pkg::CNT_BITS-1:0]          cnt;
  logic                                   out_valid;
  logic signed [plar_pkg::COORD_BITS-1:0] out_x;
  logic signed [plar_pkg::COORD_BITS-1:0] out_y;
  logic                                   out_last;
  logic                                   out_ovf;

  logic                                   free;
  logic                                   emit;
  logic [plar_pkg::SREM_BITS+1:0]         s_rem2;
  logic [plar_pkg::SREM_BITS+1:0]         s_trial;
  logic                                   s_take;
  logic [plar_pkg::LEN_BITS-1:0]          r_rem2;
  logic                                   r_take;
  logic [plar_pkg::LEN_BITS:0]            x_rem2;
  logic [plar_pkg::LEN_BITS:0]            y_rem2;
  logic                                   x_take;
  logic                                   y_take;
  logic [plar_pkg::NUM_BITS-1:0]          prodx;
  logic [plar_pkg::NUM_BITS-1:0]          prody;
  logic [plar_pkg::LEN_BITS-1:0]          rnum_c;
  logic [plar_pkg::SPAN_BITS-1:0]         span;
  logic [plar_pkg::LEN_BITS:0]            d_step;
  logic                                   last_c;
  logic [plar_pkg::LEN_BITS:0]            cx;
  logic [plar_pkg::LEN_BITS:0]            cy;

  assign free = !out_valid || point.ready;
  assign emit = free && ((state == S_START) || (state == S_EMIT));
  assign pop  = (state == S_IDLE) && head_valid;

  assign point.valid       = out_valid;
  assign point.point_x     = out_x;
  assign point.point_y     = out_y;
  assign point.last_of_run = out_last;
  assign point.overflow    = out_ovf;

  // Square root step: one bit pair per cycle
  assign s_rem2  = {srem, rad[plar_pkg::RAD_BITS-1 -: 2]};
  assign s_trial = {2'b00, root, 2'b01};
  assign s_take  = (s_rem2 >= s_trial);

  // Remainder step of (len - 1 - carry) by spacing
  assign r_rem2 = {rrem[plar_pkg::LEN_BITS-2:0], rnum[plar_pkg::LEN_BITS-1]};
  assign r_take = (r_rem2 >= plar_pkg::LEN_BITS'(sp));

  // Interpolation quotient steps, both axes side by side
  assign x_rem2 = {remx, lox[plar_pkg::MAG_BITS-1]};
  assign y_rem2 = {remy, loy[plar_pkg::MAG_BITS-1]};
  assign x_take = (x_rem2 >= {1'b0, len});
  assign y_take = (y_rem2 >= {1'b0, len});

  // Scaled magnitudes with half the divisor added for rounding
  assign prodx = plar_pkg::NUM_BITS'(seg.ax) * plar_pkg::NUM_BITS'(d)
               + plar_pkg::NUM_BITS'(len >> 1);
  assign prody = plar_pkg::NUM_BITS'(seg.ay) * plar_pkg::NUM_BITS'(d)
               + plar_pkg::NUM_BITS'(len >> 1);

  assign rnum_c = len - 1'b1 - carry;
  assign span   = plar_pkg::SPAN_BITS'(sp) * plar_pkg::SPAN_BITS'(plar_pkg::MAX_POINTS);
  assign d_step = {1'b0, d} + plar_pkg::LEN_BITS'(sp);
  assign last_c = (k == plar_pkg::K_BITS'(plar_pkg::MAX_POINTS - 1)) || (d_step >= {1'b0, len});

  // Offset the start vertex by the signed quotient
  assign cx = seg.neg_x ? {seg.px[plar_pkg::COORD_BITS-1], seg.px} - {1'b0, qx}
                        : {seg.px[plar_pkg::COORD_BITS-1], seg.px} + {1'b0, qx};
  assign cy = seg.neg_y ? {seg.py[plar_pkg::COORD_BITS-1], seg.py} - {1'b0, qy}
                        : {seg.py[plar_pkg::COORD_BITS-1], seg.py} + {1'b0, qy};

  // Sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      carry     <= plar_pkg::DIST_BITS'(plar_pkg::SPACING_RESET);
    end else begin
      // Drop the held point once taken, unless a new one replaces it
      if (out_valid && point.ready && !emit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            seg <= head;
            if (head.is_start) begin
              carry <= plar_pkg::DIST_BITS'(sp);
              state <= S_START;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_START: begin
          if (free) begin
            out_valid <= 1'b1;
            out_x     <= seg.px;
            out_y     <= seg.py;
            out_last  <= 1'b1;
            out_ovf   <= 1'b0;
            state     <= S_IDLE;
          end
        end
        S_SQUARE: begin
          sqx   <= plar_pkg::SQ_BITS'(seg.ax) * plar_pkg::SQ_BITS'(seg.ax);
          sqy   <= plar_pkg::SQ_BITS'(seg.ay) * plar_pkg::SQ_BITS'(seg.ay);
          state <= S_ADD;
        end
        S_ADD: begin
          rad   <= plar_pkg::RAD_BITS'(sqx) + plar_pkg::RAD_BITS'(sqy);
          srem  <= '0;
          root  <= '0;
          cnt   <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rad  <= rad << 2;
          srem <= s_take ? plar_pkg::SREM_BITS'(s_rem2 - s_trial)
                         : plar_pkg::SREM_BITS'(s_rem2);
          root <= {root[plar_pkg::LEN_BITS-2:0], s_take};
          cnt  <= cnt + 1'b1;
          if (cnt == plar_pkg::CNT_BITS'(plar_pkg::SQRT_STEPS - 1)) begin
            len   <= {root[plar_pkg::LEN_BITS-2:0], s_take};
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (carry >= len) begin
            carry <= carry - len;
            state <= S_IDLE;
          end else begin
            rnum  <= rnum_c;
            ovf   <= (plar_pkg::SPAN_BITS'(rnum_c) >= span);
            rrem  <= '0;
            cnt   <= '0;
            d     <= carry;
            k     <= '0;
            state <= S_REM;
          end
        end
        S_REM: begin
          rnum <= rnum << 1;
          rrem <= r_take ? r_rem2 - plar_pkg::LEN_BITS'(sp) : r_rem2;
          cnt  <= cnt + 1'b1;
          if (cnt == plar_pkg::CNT_BITS'(plar_pkg::REM_STEPS - 1)) begin
            // Carried distance: spacing - 1 - remainder
            carry <= plar_pkg::DIST_BITS'(sp) - 1'b1
                   - (r_take ? r_rem2 - plar_pkg::LEN_BITS'(sp) : r_rem2);
            state <= S_PMUL;
          end
        end
        S_PMUL: begin
          remx  <= prodx[plar_pkg::NUM_BITS-1 -: plar_pkg::LEN_BITS];
          remy  <= prody[plar_pkg::NUM_BITS-1 -: plar_pkg::LEN_BITS];
          lox   <= prodx[plar_pkg::MAG_BITS-1:0];
          loy   <= prody[plar_pkg::MAG_BITS-1:0];
          cnt   <= '0;
          state <= S_PDIV;
        end
        S_PDIV: begin
          remx <= x_take ? plar_pkg::LEN_BITS'(x_rem2 - {1'b0, len})
                         : plar_pkg::LEN_BITS'(x_rem2);
          remy <= y_take ? plar_pkg::LEN_BITS'(y_rem2 - {1'b0, len})
                         : plar_pkg::LEN_BITS'(y_rem2);
          lox  <= lox << 1;
          loy  <= loy << 1;
          qx   <= {qx[plar_pkg::MAG_BITS-2:0], x_take};
          qy   <= {qy[plar_pkg::MAG_BITS-2:0], y_take};
          cnt  <= cnt + 1'b1;
          if (cnt == plar_pkg::CNT_BITS'(plar_pkg::QUO_STEPS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (free) begin
            out_valid <= 1'b1;
            out_x     <= cx[plar_pkg::COORD_BITS-1:0];
            out_y     <= cy[plar_pkg::COORD_BITS-1:0];
            out_last  <= last_c;
            out_ovf   <= ovf;
            if (last_c) begin
              state <= S_IDLE;
            end else begin
              d     <= d_step[plar_pkg::LEN_BITS-1:0];
              k     <= k + 1'b1;
              state <= S_PMUL;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A point is only interpolated strictly inside the segment
  a_d_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_PMUL) |-> (d < len))
    else $error("point distance not inside segment");

  // The final point of a run returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EMIT) && free && last_c) |=> (state == S_IDLE))
    else $error("sequencer did not finish after last point");

  // Interpolated offset never exceeds the segment delta
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> ((qx <= seg.ax) && (qy <= seg.ay)))
    else $error("interpolation offset out of range");

  // A new transaction is taken only from idle
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> ((state == S_START) || (state == S_SQUARE)))
    else $error("pop outside idle");

endmodule

### rtl/polyline_arc_length_resampler.sv
// Polyline arc-length resampler.
// vertex channel (valid/ready): one vertex per transaction, start_of_stroke
// opens a new polyline. point channel (valid/ready): resampled points,
// last_of_run marks the last point a vertex produced, overflow marks a
// segment that needed more than MAX_POINTS points (only those are sent).
// cfg_we/cfg_wdata write the spacing register (Q16.8); the user writes it
// only while idle, a rule the block itself leaves unenforced. A front stage
// classifies each vertex against the previous one and hands it through a
// two-entry queue to a back sequencer, so vertices are taken while earlier
// ones are still processed. A stroke start is popped and then emitted. A
// segment is popped, squared and added, goes through a 25-step square root
// and a check, then a 25-step remainder by spacing, and then per emitted
// point a multiply, a 24-step division on both axes in parallel and an
// emit; a segment with no point ends after the check. The next queue entry
// is popped only once the sequencer is back in idle.
// Reset clears the queue, the previous vertex and the output valid flag and
// loads spacing and carried distance with 256. When point.ready is low the
// held point stays, the sequencer waits and the queue fills, then
// vertex.ready drops.
module polyline_arc_length_resampler (
  input  logic                              clk,
  input  logic                              rst,
  plar_vertex_if.sink                       vertex,
  plar_point_if.source                      point,
  input  logic                              cfg_we,
  input  logic [plar_pkg::SPACING_BITS-1:0] cfg_wdata
);

  logic [plar_pkg::SPACING_BITS-1:0] spacing;
  logic [plar_pkg::SPACING_BITS-1:0] sp_eff;
  logic                              push;
  plar_pkg::seg_t                    push_entry;
  logic                              full;
  logic                              pop;
  logic                              head_valid;
  plar_pkg::seg_t                    head;

  // Hold the spacing register
  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= plar_pkg::SPACING_RESET;
    end else if (cfg_we) begin
      spacing <= cfg_wdata;
    end
  end

  // A zero spacing acts as one
  assign sp_eff = (spacing == '0) ? plar_pkg::SPACING_BITS'(1) : spacing;

  plar_front u_front (
    .clk        (clk),
    .rst        (rst),
    .vertex     (vertex),
    .queue_full (full),
    .push       (push),
    .entry      (push_entry)
  );

  plar_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  plar_back u_back (
    .clk        (clk),
    .rst        (rst),
    .sp         (sp_eff),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .point      (point)
  );

endmodule
